/* rtl/wfc_pkg.sv */
package wfc_pkg;

	localparam int TEXT_BITS  = 8;
	localparam int LEN_BITS   = 4;
	localparam int SLOT_BITS  = 9;
	localparam int COUNT_OUT  = 16;

	typedef struct packed {
		logic [SLOT_BITS-1:0] slot;
		logic [COUNT_OUT-1:0] count;
		logic                 is_new;
		logic                 table_full;
		logic                 truncated;
	} result_t;

	typedef struct packed {
		logic push;
		logic full;
	} queue_ctl_t;

	function automatic logic is_delim(input logic [TEXT_BITS-1:0] c);
		logic d;
		case (c)
			8'h20, 8'h0a, 8'h22, 8'h2e, 8'h2c, 8'h3b,
			8'h3a, 8'h21, 8'h3f, 8'h28, 8'h29: d = 1'b1;
			default: d = 1'b0;
		endcase
		return d;
	endfunction

endpackage

/* rtl/wfc_byte_if.sv */
interface wfc_byte_if;
	logic                            valid;
	logic                            ready;
	logic [wfc_pkg::TEXT_BITS-1:0]   text_byte;
	logic                            end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

/* rtl/wfc_result_if.sv */
interface wfc_result_if;
	logic                            valid;
	logic                            ready;
	logic [wfc_pkg::SLOT_BITS-1:0]   slot;
	logic [wfc_pkg::COUNT_OUT-1:0]   count;
	logic                            is_new;
	logic                            table_full;
	logic                            truncated;

	modport source (output valid, output slot, output count, output is_new,
		output table_full, output truncated, input ready);
	modport sink (input valid, input slot, input count, input is_new,
		input table_full, input truncated, output ready);
endinterface

/* rtl/wfc_ram.sv */
module wfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/wfc_front.sv */
module wfc_front #(
	parameter int WORD_CHARS = 11
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	wfc_byte_if.sink                                   in,
	input  wfc_pkg::queue_ctl_t                        q_in,
	output wfc_pkg::queue_ctl_t                        q_out,
	output logic [WORD_CHARS*wfc_pkg::TEXT_BITS+wfc_pkg::LEN_BITS:0] word
);
	localparam int CW = WORD_CHARS * wfc_pkg::TEXT_BITS;
	localparam logic [wfc_pkg::LEN_BITS-1:0] WC = wfc_pkg::LEN_BITS'(WORD_CHARS);

	logic [CW-1:0]                 chars_q;
	logic [wfc_pkg::LEN_BITS-1:0]  len_q;
	logic                          cut_q;
	logic [CW-1:0]                 chars_n;
	logic [wfc_pkg::LEN_BITS-1:0]  len_n;
	logic                          cut_n;
	logic                          take;
	logic                          delim;
	logic                          push;

	assign in.ready = !q_in.full;
	assign take     = in.valid && in.ready;
	assign delim    = wfc_pkg::is_delim(in.text_byte);

	always_comb begin
		chars_n = chars_q;
		len_n   = len_q;
		cut_n   = cut_q;
		if (len_q < WC) begin
			len_n = len_q + 1'b1;
		end else begin
			cut_n = 1'b1;
		end
		for (int i = 0; i < WORD_CHARS; i++) begin
			if (len_q == wfc_pkg::LEN_BITS'(i)) begin
				chars_n[i*wfc_pkg::TEXT_BITS +: wfc_pkg::TEXT_BITS] = in.text_byte;
			end
		end
	end

	always_comb begin
		push = 1'b0;
		word = {cut_n, len_n, chars_n};
		if (take) begin
			if (delim) begin
				push = len_q != '0;
				word = {cut_q, len_q, chars_q};
			end else begin
				push = in.end_of_text;
			end
		end
	end

	assign q_out.push = push;
	assign q_out.full = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			cut_q <= 1'b0;
		end else if (take) begin
			if (push || delim) begin
				len_q <= '0;
				cut_q <= 1'b0;
			end else begin
				len_q <= len_n;
				cut_q <= cut_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !delim) begin
			chars_q <= chars_n;
		end
	end
endmodule

/* rtl/wfc_queue.sv */
module wfc_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	output logic             empty,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] data_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = data_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_q] <= wdata;
		end
	end
endmodule

/* rtl/wfc_back.sv */
module wfc_back #(
	parameter int TABLE_DEPTH = 512,
	parameter int WORD_CHARS  = 11,
	parameter int COUNT_BITS  = 16
) (
	input  logic                                                      clk,
	input  logic                                                      arst_n,
	input  logic                                                      q_empty,
	output logic                                                      q_pop,
	input  logic [WORD_CHARS*wfc_pkg::TEXT_BITS+wfc_pkg::LEN_BITS:0] word,
	wfc_result_if.source                                              out
);
	localparam int CW = WORD_CHARS * wfc_pkg::TEXT_BITS;
	localparam int RW = CW + wfc_pkg::LEN_BITS;
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int UW = $clog2(TABLE_DEPTH + 1);
	localparam logic [UW-1:0] FULL_USED = UW'(TABLE_DEPTH);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_CMP  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t                       state_q;
	logic [UW-1:0]                used_q;
	logic [IW-1:0]                idx_q;
	logic [RW-1:0]                word_q;
	logic                         cut_q;
	wfc_pkg::result_t             res_q;
	wfc_pkg::result_t             out_q;
	logic                         out_valid_q;

	logic [RW-1:0]                row_rd;
	logic [COUNT_BITS-1:0]        cnt_rd;
	logic                         w_we;
	logic [IW-1:0]                w_addr;
	logic                         c_we;
	logic [IW-1:0]                c_addr;
	logic [COUNT_BITS-1:0]        c_data;
	logic                         match;
	logic                         last_entry;
	logic [COUNT_BITS-1:0]        cnt_inc;
	logic [wfc_pkg::LEN_BITS-1:0] wlen;

	assign wlen = word_q[RW-1:CW];

	always_comb begin
		match = row_rd[RW-1:CW] == wlen;
		for (int i = 0; i < WORD_CHARS; i++) begin
			if (wfc_pkg::LEN_BITS'(i) < wlen &&
				row_rd[i*wfc_pkg::TEXT_BITS +: wfc_pkg::TEXT_BITS] !=
				word_q[i*wfc_pkg::TEXT_BITS +: wfc_pkg::TEXT_BITS]) begin
				match = 1'b0;
			end
		end
	end

	assign last_entry = UW'(idx_q) + 1'b1 == used_q;
	assign cnt_inc    = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
	assign q_pop      = (state_q == S_IDLE) && !q_empty;

	always_comb begin
		w_we   = 1'b0;
		c_we   = 1'b0;
		w_addr = used_q[IW-1:0];
		c_addr = used_q[IW-1:0];
		c_data = COUNT_BITS'(1);
		if (state_q == S_IDLE && !q_empty && used_q == '0) begin
			w_we = 1'b1;
			c_we = 1'b1;
		end else if (state_q == S_CMP) begin
			if (match) begin
				c_we   = 1'b1;
				c_addr = idx_q;
				c_data = cnt_inc;
			end else if (last_entry && used_q != FULL_USED) begin
				w_we = 1'b1;
				c_we = 1'b1;
			end
		end
	end

	wfc_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_words (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_addr),
		.wdata (state_q == S_IDLE ? word[RW-1:0] : word_q),
		.raddr (idx_q),
		.rdata (row_rd)
	);

	wfc_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_DEPTH)) u_counts (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_addr),
		.wdata (c_data),
		.raddr (idx_q),
		.rdata (cnt_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out.valid && out.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (!q_empty) begin
						if (used_q == '0) begin
							used_q  <= used_q + 1'b1;
							state_q <= S_OUT;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (match || last_entry) begin
						if (!match && used_q != FULL_USED) begin
							used_q <= used_q + 1'b1;
						end
						state_q <= S_OUT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			word_q <= word[RW-1:0];
			cut_q  <= word[RW];
			res_q  <= '{slot: '0, count: wfc_pkg::COUNT_OUT'(1), is_new: 1'b1,
				table_full: 1'b0, truncated: word[RW]};
		end
		if (state_q == S_CMP) begin
			if (match) begin
				res_q <= '{slot: wfc_pkg::SLOT_BITS'(idx_q),
					count: wfc_pkg::COUNT_OUT'(cnt_inc), is_new: 1'b0,
					table_full: 1'b0, truncated: cut_q};
			end else if (last_entry) begin
				if (used_q != FULL_USED) begin
					res_q <= '{slot: wfc_pkg::SLOT_BITS'(used_q),
						count: wfc_pkg::COUNT_OUT'(1), is_new: 1'b1,
						table_full: 1'b0, truncated: cut_q};
				end else begin
					res_q <= '{slot: '0, count: '0, is_new: 1'b0,
						table_full: 1'b1, truncated: cut_q};
				end
			end
		end
		if (state_q == S_OUT && (!out_valid_q || out.ready)) begin
			out_q <= res_q;
		end
	end

	assign out.valid      = out_valid_q;
	assign out.slot       = out_q.slot;
	assign out.count      = out_q.count;
	assign out.is_new     = out_q.is_new;
	assign out.table_full = out_q.table_full;
	assign out.truncated  = out_q.truncated;
endmodule

/* rtl/word_frequency_counter.sv */
// Lookup: after a word leaves the front queue, the back walks the table entries in turn,
// one registered RAM read and one compare per entry, then registers the result for output.
// Throughput: one byte per cycle into the front while the queue is not full; the back takes
// a new word only when done with the last, set by the sequential walk over the word table.
// Reset: asynchronous, active low; clears the pending word, queue, table fill count
// and output valid. Table RAMs are not cleared.
module word_frequency_counter #(
	parameter int TABLE_DEPTH = 512,
	parameter int WORD_CHARS  = 11,
	parameter int COUNT_BITS  = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	wfc_byte_if.sink     in,
	wfc_result_if.source out
);
	localparam int QW = WORD_CHARS * wfc_pkg::TEXT_BITS + wfc_pkg::LEN_BITS + 1;

	wfc_pkg::queue_ctl_t q_to_front;
	wfc_pkg::queue_ctl_t q_from_front;
	logic [QW-1:0]       word_in;
	logic [QW-1:0]       word_out;
	logic                q_empty;
	logic                q_pop;

	wfc_front #(.WORD_CHARS(WORD_CHARS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in),
		.q_in   (q_to_front),
		.q_out  (q_from_front),
		.word   (word_in)
	);

	assign q_to_front.push = q_from_front.push;

	wfc_queue #(.WIDTH(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_from_front.push),
		.wdata  (word_in),
		.full   (q_to_front.full),
		.empty  (q_empty),
		.pop    (q_pop),
		.rdata  (word_out)
	);

	wfc_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.WORD_CHARS  (WORD_CHARS),
		.COUNT_BITS  (COUNT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.word    (word_out),
		.out     (out)
	);
endmodule
